// ===== rtl/htdc8_pkg.sv =====
// ---------------------------------------------------------------------------
// htdc8_pkg: shared definitions for the header/trailer deframer
// Frame markers, CRC-8 step function and result flag layout.
// ---------------------------------------------------------------------------
package htdc8_pkg;

  // Longest frame, in bytes, header and checksum included
  localparam int unsigned MaxFrameLenDefault = 80;

  // Header bytes and trailer prefix (three bytes before the checksum)
  localparam logic [7:0]  HdrFirst   = 8'hEB;
  localparam logic [7:0]  HdrSecond  = 8'h90;
  localparam logic [23:0] TrailerPre = 24'hFFFF01;

  // CRC-8, polynomial x^8 + x^2 + x + 1, MSB first
  localparam logic [7:0] CrcPoly = 8'h07;

  // Advance the CRC by one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC after both header bytes, seeded from zero
  localparam logic [7:0] HdrCrc = crc8_step(crc8_step(8'h00, HdrFirst), HdrSecond);

  // Result flags carried on the user sideband, highest bit first
  typedef struct packed {
    logic overflow_drop;
    logic crc_ok;
    logic frame_start;
    logic stored;
  } res_flags_t;

endpackage

// ===== rtl/header_trailer_deframer_crc8_core.sv =====
// ---------------------------------------------------------------------------
// header_trailer_deframer_crc8_core: serial byte deframer with CRC-8 check
// Finds EB 90, tracks frame position, ends the frame on FF FF 01 plus a
// checksum byte and checks it against a running CRC-8; drops overlong frames.
// ---------------------------------------------------------------------------
//
//  channel | dir | beat contents
//  --------+-----+----------------------------------------------------------
//  in_     | in  | tdata[7:0] rx_byte
//  out_    | out | tdata position, data_byte; tuser flags; tlast frame_end
//
//  One beat in, one beat out; a new byte is taken every cycle unless the output stalls.
//  Each byte is decoded in the cycle it is accepted and its result lands in
//  the output register on that edge.
//  The output register is refilled on the edge it is drained, so a stall
//  only holds the input while a result waits and out_tready is low.
//  Synchronous active-low reset clears history, position, CRC and valid.
//
module header_trailer_deframer_crc8_core #(
  parameter int unsigned MAX_FRAME_LEN = htdc8_pkg::MaxFrameLenDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] position, [15:8] data_byte
  output logic [3:0]  out_tuser,  // [0] stored, [1] frame_start, [2] crc_ok,
                                  // [3] overflow_drop
  output logic        out_tlast   // frame_end
);
  import htdc8_pkg::*;

  localparam logic [8:0] MaxLen = 9'(MAX_FRAME_LEN);

  // Decode state
  logic [23:0] hist_r,  hist_nxt;
  logic [7:0]  pos_r,   pos_nxt;
  logic [7:0]  crc_r,   crc_nxt;

  // Output register
  logic        out_valid_r;
  logic [7:0]  out_pos_r,  res_pos;
  logic [7:0]  out_data_r;
  res_flags_t  out_flags_r, res_flags;
  logic        out_last_r, res_last;

  logic        in_acc;
  logic        hdr_hit;
  logic        trl_hit;
  logic        full_hit;

  // Take a beat whenever the output register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign hdr_hit  = (hist_r[7:0] == HdrFirst) && (in_tdata == HdrSecond);
  assign trl_hit  = (hist_r == TrailerPre);
  assign full_hit = ({1'b0, pos_r} + 9'd1) >= MaxLen;

  // Decode one byte: result fields and next state
  always_comb begin
    hist_nxt  = {hist_r[15:0], in_tdata};
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    res_pos   = 8'd0;
    res_flags = '0;
    res_last  = 1'b0;
    if (pos_r == 8'd0) begin
      if (hdr_hit) begin
        res_flags.stored      = 1'b1;
        res_flags.frame_start = 1'b1;
        res_pos               = 8'd1;
        crc_nxt               = HdrCrc;
        pos_nxt               = 8'd2;
      end
    end else begin
      res_flags.stored = 1'b1;
      res_pos          = pos_r;
      if (trl_hit) begin
        res_last         = 1'b1;
        res_flags.crc_ok = (crc_r == in_tdata);
        pos_nxt          = 8'd0;
        crc_nxt          = 8'd0;
      end else if (full_hit) begin
        res_flags.overflow_drop = 1'b1;
        pos_nxt                 = 8'd0;
        crc_nxt                 = 8'd0;
      end else begin
        crc_nxt = crc8_step(crc_r, in_tdata);
        pos_nxt = pos_r + 8'd1;
      end
    end
  end

  // Advance decode state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      pos_r  <= '0;
      crc_r  <= '0;
    end else if (in_acc) begin
      hist_r <= hist_nxt;
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_pos_r   <= res_pos;
      out_data_r  <= in_tdata;
      out_flags_r <= res_flags;
      out_last_r  <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r, out_pos_r};
  assign out_tuser  = out_flags_r;
  assign out_tlast  = out_last_r;

  // A byte outside a frame carries position zero, inside one never
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_flags_r.stored == (out_pos_r != 8'd0)))
    else $error("position does not agree with stored flag");

  // Start, end and drop are mutually exclusive, and crc_ok needs frame end
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($onehot0({out_flags_r.frame_start, out_last_r,
                               out_flags_r.overflow_drop})
                     && (!out_flags_r.crc_ok || out_last_r)))
    else $error("conflicting frame flags");

  // A frame start leaves the decoder at position two with the header CRC
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_flags.frame_start) |=> (pos_r == 8'd2 && crc_r == HdrCrc))
    else $error("frame start did not seed position and CRC");

  // Position never reaches the frame limit
  assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pos_r} < MaxLen)
    else $error("frame position ran past limit");

endmodule

// ===== tb/sv/tb_header_trailer_deframer_crc8_core.sv =====
// ---------------------------------------------------------------------------
// tb_header_trailer_deframer_crc8_core: self-checking bench for the deframer
// Drives byte beats with random gaps and output stalls, keeps a byte-level
// model of the header search, frame position and CRC-8, and checks every
// result beat field by field in order.
// ---------------------------------------------------------------------------
module tb_header_trailer_deframer_crc8_core;
  import htdc8_pkg::*;

  localparam int unsigned FRAME_MAX      = MaxFrameLenDefault;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          ITEM_TARGET    = 1600;

  typedef struct {
    bit       stored;
    bit [7:0] position;
    bit [7:0] data_byte;
    bit       frame_start;
    bit       frame_end;
    bit       crc_ok;
    bit       overflow_drop;
  } deframe_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;    // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // [7:0] position, [15:8] data_byte
  logic [3:0]  out_tuser;           // [0] stored, [1] frame_start, [2] crc_ok,
                                    // [3] overflow_drop
  logic        out_tlast;           // frame_end

  // model state
  bit [23:0]    rx_hist = '0;
  bit [7:0]     frame_pos = '0;
  bit [7:0]     frame_crc = '0;
  deframe_res_t pending_results[$];

  int  err_count = 0;
  int  items_sent = 0;
  int  quiet_cycles = 0;
  bit  gaps_on = 1'b1;

  header_trailer_deframer_crc8_core #(
    .MAX_FRAME_LEN(FRAME_MAX)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  // CRC-8, poly 0x07, fed one data bit at a time from the MSB
  function automatic bit [7:0] crc8_byte(bit [7:0] crc, bit [7:0] d);
    bit fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[7] ^ d[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return crc;
  endfunction

  // Advance the deframer model by one byte and queue its result
  function automatic void predict_deframe(bit [7:0] b);
    bit [31:0]    win;
    deframe_res_t r;
    win = {rx_hist, b};
    r = '{default: '0};
    r.data_byte = b;
    if (frame_pos == 8'd0) begin
      if (win[15:0] == {HdrFirst, HdrSecond}) begin
        r.stored      = 1'b1;
        r.position    = 8'd1;
        r.frame_start = 1'b1;
        frame_crc     = crc8_byte(crc8_byte(8'h00, HdrFirst), HdrSecond);
        frame_pos     = 8'd2;
      end
    end else begin
      r.stored   = 1'b1;
      r.position = frame_pos;
      if (win[31:8] == TrailerPre) begin
        r.frame_end = 1'b1;
        r.crc_ok    = (frame_crc == b);
        frame_pos   = 8'd0;
        frame_crc   = 8'd0;
      end else if (int'(frame_pos) + 1 >= int'(FRAME_MAX)) begin
        r.overflow_drop = 1'b1;
        frame_pos       = 8'd0;
        frame_crc       = 8'd0;
      end else begin
        frame_crc = crc8_byte(frame_crc, b);
        frame_pos = frame_pos + 8'd1;
      end
    end
    rx_hist = win[23:0];
    pending_results.push_back(r);
  endfunction

  // Check result beats, record accepted input beats, watch for a hang
  always @(posedge clk) begin
    deframe_res_t e;
    res_flags_t   f;
    if (out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tuser %h tlast %b",
               out_tdata, out_tuser, out_tlast);
        err_count++;
      end else begin
        e = pending_results.pop_front();
        f = out_tuser;
        if (f.stored !== e.stored) begin
          $error("stored: expected %0d, actual %0d", e.stored, f.stored);
          err_count++;
        end
        if (out_tdata[7:0] !== e.position) begin
          $error("position: expected %0d, actual %0d", e.position, out_tdata[7:0]);
          err_count++;
        end
        if (out_tdata[15:8] !== e.data_byte) begin
          $error("data_byte: expected %h, actual %h", e.data_byte, out_tdata[15:8]);
          err_count++;
        end
        if (f.frame_start !== e.frame_start) begin
          $error("frame_start: expected %0d, actual %0d", e.frame_start, f.frame_start);
          err_count++;
        end
        if (out_tlast !== e.frame_end) begin
          $error("frame_end: expected %0d, actual %0d", e.frame_end, out_tlast);
          err_count++;
        end
        if (f.crc_ok !== e.crc_ok) begin
          $error("crc_ok: expected %0d, actual %0d", e.crc_ok, f.crc_ok);
          err_count++;
        end
        if (f.overflow_drop !== e.overflow_drop) begin
          $error("overflow_drop: expected %0d, actual %0d", e.overflow_drop,
                 f.overflow_drop);
          err_count++;
        end
      end
    end
    if (in_tvalid && in_tready) begin
      predict_deframe(in_tdata);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Stall the result side at random unless gaps are switched off
  always @(posedge clk) begin
    out_tready <= !gaps_on || ($urandom_range(99) >= 30);
  end

  // Drive one byte beat and hold it until it is taken
  task automatic send_byte(input bit [7:0] b);
    if (gaps_on && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random byte, steered toward the marker values bias_pct of the time
  function automatic bit [7:0] pick_byte(int bias_pct);
    bit [7:0] marks[4];
    marks = '{HdrFirst, HdrSecond, 8'hFF, 8'h01};
    if ($urandom_range(99) < bias_pct) return marks[$urandom_range(3)];
    return 8'($urandom_range(255));
  endfunction

  // Send header, payload, trailer prefix and a good or corrupted checksum
  task automatic send_frame(input int plen, input bit good);
    bit [7:0] crc;
    bit [7:0] b;
    crc = 8'h00;
    send_byte(HdrFirst);
    crc = crc8_byte(crc, HdrFirst);
    send_byte(HdrSecond);
    crc = crc8_byte(crc, HdrSecond);
    for (int i = 0; i < plen; i++) begin
      b = pick_byte(5);
      send_byte(b);
      crc = crc8_byte(crc, b);
    end
    for (int i = 2; i >= 0; i--) begin
      send_byte(TrailerPre[i*8 +: 8]);
      crc = crc8_byte(crc, TrailerPre[i*8 +: 8]);
    end
    send_byte(good ? crc : crc ^ 8'($urandom_range(1, 255)));
  endtask

  // Byte extremes, good and bad checksum, checksum that opens the next frame
  task automatic test_directed();
    bit [7:0] min_crc;
    min_crc = 8'h00;
    min_crc = crc8_byte(min_crc, HdrFirst);
    min_crc = crc8_byte(min_crc, HdrSecond);
    for (int i = 2; i >= 0; i--) min_crc = crc8_byte(min_crc, TrailerPre[i*8 +: 8]);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(0, 1'b1);
    send_frame(0, 1'b0);
    // checksum byte EB, then 90 starts a new frame immediately
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    for (int i = 2; i >= 0; i--) send_byte(TrailerPre[i*8 +: 8]);
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    for (int i = 2; i >= 0; i--) send_byte(TrailerPre[i*8 +: 8]);
    send_byte(min_crc);
  endtask

  // Checksum on the last slot, one byte too long, and a frame with no trailer
  task automatic test_length_limits();
    send_frame(int'(FRAME_MAX) - 6, 1'b1);
    send_frame(int'(FRAME_MAX) - 5, 1'b1);
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    for (int i = 0; i < int'(FRAME_MAX) + 5; i++) send_byte(pick_byte(0));
    // hold the sender until the pipe is empty
    wait_drain();
  endtask

  // Mostly well-formed frames, some noise and cut-off frames
  task automatic random_traffic(input int upto);
    int sel;
    int n;
    while (items_sent < upto) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(int'(FRAME_MAX) - 10, FRAME_MAX)
                                     : $urandom_range(16);
        send_frame(n, $urandom_range(3) != 0);
      end else if (sel < 85) begin
        repeat ($urandom_range(1, 6)) send_byte(pick_byte(40));
      end else begin
        send_byte(HdrFirst);
        send_byte(HdrSecond);
        repeat ($urandom_range(8)) send_byte(pick_byte(10));
        case ($urandom_range(2))
          0: begin
            send_byte(8'hFF);
            send_byte(8'hFF);
          end
          1: begin
            send_byte(8'hFF);
            send_byte(8'h01);
          end
          default: send_byte(HdrFirst);
        endcase
      end
    end
  endtask

  // Random traffic with gaps, then a stretch without, then gaps again
  task automatic test_random();
    random_traffic(900);
    gaps_on = 1'b0;
    random_traffic(1200);
    gaps_on = 1'b1;
    random_traffic(ITEM_TARGET);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_length_limits();
    test_random();
    wait_drain();
    repeat (4) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
